[rtl/core/tmaa_pkg.sv]
// shared constants, types and register codes of the triangle mesh area accumulator
package tmaa_pkg;

   localparam int COORD_BITS     = 16;
   localparam int TRI_COUNT_BITS = 16;

   localparam int CFG_W  = 16;
   localparam int DATA_W = 32;

   localparam int EDGE_W = COORD_BITS + 1;
   localparam int PX_W   = 2 * EDGE_W;
   localparam int DIFF_W = PX_W + 1;
   localparam int MAG_W  = 2 * COORD_BITS + 2;
   localparam int RAD_W  = 2 * MAG_W;
   localparam int ROOT_W = MAG_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int CNT_W  = $clog2(ROOT_STEPS);

   localparam int SUM_BITS  = 2 * COORD_BITS + 3 + TRI_COUNT_BITS;
   localparam int LAM_BITS  = SUM_BITS - 1;
   localparam int LAM_W     = 50;
   localparam int SCALED_W  = 63;
   localparam int SCALE_FRAC2 = 24;
   localparam int K_DIGITS  = 3;
   localparam int K_W       = K_DIGITS * CFG_W;
   localparam int SAT_LO    = SCALED_W + SCALE_FRAC2;
   localparam int AP_W      = (LAM_BITS + K_W > SAT_LO) ? LAM_BITS + K_W : SAT_LO + 1;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int REG_IDX_W = 1;
   localparam int ADDR_W    = REG_IDX_W + 2;
   localparam logic [REG_IDX_W-1:0] REG_CARD_SCALE     = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_INSTANCE_COUNT = 1'b1;
   localparam logic [CFG_W-1:0] CARD_SCALE_RST     = 16'd410;
   localparam logic [CFG_W-1:0] INSTANCE_COUNT_RST = 16'd0;

   typedef struct packed {
      logic [MAG_W-1:0] ux;
      logic [MAG_W-1:0] uy;
      logic [MAG_W-1:0] uz;
      logic             last;
   } mag_type;

endpackage

[rtl/core/tmaa_intf.sv]
// triangle and result channel interfaces
interface tmaa_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tmaa_pkg::COORD_BITS-1:0] ax;
   logic signed [tmaa_pkg::COORD_BITS-1:0] ay;
   logic signed [tmaa_pkg::COORD_BITS-1:0] az;
   logic signed [tmaa_pkg::COORD_BITS-1:0] bx;
   logic signed [tmaa_pkg::COORD_BITS-1:0] by;
   logic signed [tmaa_pkg::COORD_BITS-1:0] bz;
   logic signed [tmaa_pkg::COORD_BITS-1:0] cx_in;
   logic signed [tmaa_pkg::COORD_BITS-1:0] cy_in;
   logic signed [tmaa_pkg::COORD_BITS-1:0] cz_in;
   logic                                  last_triangle;

   modport source (
      output valid, ax, ay, az, bx, by, bz, cx_in, cy_in, cz_in, last_triangle,
      input  ready
   );
   modport sink (
      input  valid, ax, ay, az, bx, by, bz, cx_in, cy_in, cz_in, last_triangle,
      output ready
   );
endinterface

interface tmaa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tmaa_pkg::LAM_W-1:0]      lamina_area;
   logic [tmaa_pkg::SCALED_W-1:0]   scaled_area;
   logic                            area_saturated;

   modport source (
      output valid, lamina_area, scaled_area, area_saturated,
      input  ready
   );
   modport sink (
      input  valid, lamina_area, scaled_area, area_saturated,
      output ready
   );
endinterface

[rtl/core/tmaa_front.sv]
// front pipeline: edge vectors, cross product and component magnitudes
module tmaa_front (
   input  logic              clock,
   input  logic              reset,
   tmaa_req_if.sink          req_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output tmaa_pkg::mag_type push_data
);

   function automatic logic [tmaa_pkg::MAG_W-1:0] abs_diff(
      input logic signed [tmaa_pkg::PX_W-1:0] a,
      input logic signed [tmaa_pkg::PX_W-1:0] b
   );
      logic signed [tmaa_pkg::DIFF_W-1:0] d;
      d = {a[tmaa_pkg::PX_W-1], a} - {b[tmaa_pkg::PX_W-1], b};
      if (d[tmaa_pkg::DIFF_W-1]) begin
         d = -d;
      end
      return d[tmaa_pkg::MAG_W-1:0];
   endfunction

   logic adv;

   logic                                   s1_valid_ff, s1_valid_in;
   logic                                   s1_last_ff;
   logic signed [tmaa_pkg::EDGE_W-1:0]     e0x_ff, e0y_ff, e0z_ff, e1x_ff, e1y_ff, e1z_ff;
   logic signed [tmaa_pkg::EDGE_W-1:0]     e0x_in, e0y_in, e0z_in, e1x_in, e1y_in, e1z_in;

   logic                                   s2_valid_ff;
   logic                                   s2_last_ff;
   logic signed [tmaa_pkg::PX_W-1:0]       m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [tmaa_pkg::PX_W-1:0]       m0_in, m1_in, m2_in, m3_in, m4_in, m5_in;

   logic                                   s3_valid_ff;
   tmaa_pkg::mag_type                      mag_ff, mag_in;

   assign adv            = !s3_valid_ff || push_ready;
   assign req_chan.ready = adv;
   assign s1_valid_in    = req_chan.valid;

   assign e0x_in = {req_chan.bx[tmaa_pkg::COORD_BITS-1], req_chan.bx}
                 - {req_chan.ax[tmaa_pkg::COORD_BITS-1], req_chan.ax};
   assign e0y_in = {req_chan.by[tmaa_pkg::COORD_BITS-1], req_chan.by}
                 - {req_chan.ay[tmaa_pkg::COORD_BITS-1], req_chan.ay};
   assign e0z_in = {req_chan.bz[tmaa_pkg::COORD_BITS-1], req_chan.bz}
                 - {req_chan.az[tmaa_pkg::COORD_BITS-1], req_chan.az};
   assign e1x_in = {req_chan.cx_in[tmaa_pkg::COORD_BITS-1], req_chan.cx_in}
                 - {req_chan.ax[tmaa_pkg::COORD_BITS-1], req_chan.ax};
   assign e1y_in = {req_chan.cy_in[tmaa_pkg::COORD_BITS-1], req_chan.cy_in}
                 - {req_chan.ay[tmaa_pkg::COORD_BITS-1], req_chan.ay};
   assign e1z_in = {req_chan.cz_in[tmaa_pkg::COORD_BITS-1], req_chan.cz_in}
                 - {req_chan.az[tmaa_pkg::COORD_BITS-1], req_chan.az};

   assign m0_in = e0y_ff * e1z_ff;
   assign m1_in = e0z_ff * e1y_ff;
   assign m2_in = e0z_ff * e1x_ff;
   assign m3_in = e0x_ff * e1z_ff;
   assign m4_in = e0x_ff * e1y_ff;
   assign m5_in = e0y_ff * e1x_ff;

   assign mag_in.ux   = abs_diff(m0_ff, m1_ff);
   assign mag_in.uy   = abs_diff(m2_ff, m3_ff);
   assign mag_in.uz   = abs_diff(m4_ff, m5_ff);
   assign mag_in.last = s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff <= req_chan.last_triangle;
         e0x_ff     <= e0x_in;
         e0y_ff     <= e0y_in;
         e0z_ff     <= e0z_in;
         e1x_ff     <= e1x_in;
         e1y_ff     <= e1y_in;
         e1z_ff     <= e1z_in;
         s2_last_ff <= s1_last_ff;
         m0_ff      <= m0_in;
         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         m3_ff      <= m3_in;
         m4_ff      <= m4_in;
         m5_ff      <= m5_in;
         mag_ff     <= mag_in;
      end
   end

   assign push_valid = s3_valid_ff;
   assign push_data  = mag_ff;

endmodule

[rtl/core/tmaa_queue.sv]
// small fifo between the front pipeline and the root sequencer
module tmaa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tmaa_pkg::mag_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tmaa_pkg::mag_type pop_data
);

   tmaa_pkg::mag_type                 mem_ff [tmaa_pkg::QDEPTH];
   logic [tmaa_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tmaa_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tmaa_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign push_ready = cnt_ff != tmaa_pkg::QCNT_W'(tmaa_pkg::QDEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == tmaa_pkg::QPTR_W'(tmaa_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == tmaa_pkg::QPTR_W'(tmaa_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/tmaa_back.sv]
// back sequencer: squared length, digit-by-digit root, accumulate and scale
module tmaa_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  tmaa_pkg::mag_type          pop_data,
   input  logic [tmaa_pkg::CFG_W-1:0] card_scale,
   input  logic [tmaa_pkg::CFG_W-1:0] instance_count,
   tmaa_rsp_if.source                 rsp_chan
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_ROOT = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_KA   = 3'd4;
   localparam logic [2:0] ST_KB   = 3'd5;
   localparam logic [2:0] ST_MUL  = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   localparam int SQ_TERMS = 3;

   logic [2:0]                          state_ff, state_in;
   logic [tmaa_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [tmaa_pkg::SUM_BITS-1:0]       sum_ff, sum_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   tmaa_pkg::mag_type                   mag_ff, mag_in;
   logic [tmaa_pkg::RAD_W-1:0]          rad_ff, rad_in;
   logic [tmaa_pkg::REM_W-1:0]          rem_ff, rem_in;
   logic [tmaa_pkg::ROOT_W-1:0]         root_ff, root_in;
   logic [tmaa_pkg::LAM_BITS-1:0]       lam_ff, lam_in;
   logic [tmaa_pkg::K_W-1:0]            k_ff, k_in;
   logic [tmaa_pkg::AP_W-1:0]           p_ff, p_in;
   logic [tmaa_pkg::LAM_W-1:0]          rsp_lam_ff, rsp_lam_in;
   logic [tmaa_pkg::SCALED_W-1:0]       rsp_scaled_ff, rsp_scaled_in;
   logic                                rsp_sat_ff, rsp_sat_in;

   logic [tmaa_pkg::MAG_W-1:0]          sq_op;
   logic [tmaa_pkg::RAD_W-1:0]          sq_prod;
   logic [tmaa_pkg::REM_W+1:0]          rem_wide, trial, rem_next;
   logic                                rem_ge;
   logic [tmaa_pkg::SUM_BITS:0]         sum_wide;
   logic [tmaa_pkg::SUM_BITS-1:0]       sum_sat;
   logic [2*tmaa_pkg::CFG_W-1:0]        ksq;
   logic [tmaa_pkg::K_W-1:0]            kfull;
   logic [tmaa_pkg::LAM_BITS+tmaa_pkg::CFG_W-1:0] mul_part;
   logic                                sat;
   logic [tmaa_pkg::SCALED_W-1:0]       scaled;
   logic                                out_free;

   always_comb begin
      case (cnt_ff)
         tmaa_pkg::CNT_W'(0): sq_op = mag_ff.ux;
         tmaa_pkg::CNT_W'(1): sq_op = mag_ff.uy;
         default:             sq_op = mag_ff.uz;
      endcase
   end

   assign sq_prod  = sq_op * sq_op;
   assign rem_wide = {rem_ff, rad_ff[tmaa_pkg::RAD_W-1 -: 2]};
   assign trial    = (tmaa_pkg::REM_W + 2)'({root_ff, 2'b01});
   assign rem_ge   = rem_wide >= trial;
   assign rem_next = rem_ge ? rem_wide - trial : rem_wide;
   assign sum_wide = {1'b0, sum_ff} + (tmaa_pkg::SUM_BITS + 1)'(root_ff);
   assign sum_sat  = sum_wide[tmaa_pkg::SUM_BITS] ? '1 : sum_wide[tmaa_pkg::SUM_BITS-1:0];
   assign ksq      = card_scale * card_scale;
   assign kfull    = k_ff[2*tmaa_pkg::CFG_W-1:0] * instance_count;
   assign mul_part = lam_ff * k_ff[tmaa_pkg::K_W-1 -: tmaa_pkg::CFG_W];
   assign sat      = |p_ff[tmaa_pkg::AP_W-1:tmaa_pkg::SAT_LO];
   assign scaled   = sat ? '1 : p_ff[tmaa_pkg::SAT_LO-1:tmaa_pkg::SCALE_FRAC2];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      mag_in        = mag_ff;
      rad_in        = rad_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      lam_in        = lam_ff;
      k_in          = k_ff;
      p_in          = p_ff;
      rsp_lam_in    = rsp_lam_ff;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_sat_in    = rsp_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               mag_in   = pop_data;
               rad_in   = '0;
               cnt_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            rad_in = rad_ff + sq_prod;
            if (cnt_ff == tmaa_pkg::CNT_W'(SQ_TERMS - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            rad_in  = rad_ff << 2;
            rem_in  = rem_next[tmaa_pkg::REM_W-1:0];
            root_in = {root_ff[tmaa_pkg::ROOT_W-2:0], rem_ge};
            if (cnt_ff == tmaa_pkg::CNT_W'(tmaa_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_ACC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ACC: begin
            if (mag_ff.last) begin
               lam_in   = sum_sat[tmaa_pkg::SUM_BITS-1:1];
               sum_in   = '0;
               state_in = ST_KA;
            end else begin
               sum_in   = sum_sat;
               state_in = ST_IDLE;
            end
         end
         ST_KA: begin
            k_in     = tmaa_pkg::K_W'(ksq);
            state_in = ST_KB;
         end
         ST_KB: begin
            k_in     = kfull;
            p_in     = '0;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            p_in = (p_ff << tmaa_pkg::CFG_W) + tmaa_pkg::AP_W'(mul_part);
            k_in = k_ff << tmaa_pkg::CFG_W;
            if (cnt_ff == tmaa_pkg::CNT_W'(tmaa_pkg::K_DIGITS - 1)) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_lam_in    = tmaa_pkg::LAM_W'(lam_ff);
               rsp_scaled_in = scaled;
               rsp_sat_in    = sat;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      rad_ff        <= rad_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      lam_ff        <= lam_in;
      k_ff          <= k_in;
      p_ff          <= p_in;
      rsp_lam_ff    <= rsp_lam_in;
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.lamina_area    = rsp_lam_ff;
   assign rsp_chan.scaled_area    = rsp_scaled_ff;
   assign rsp_chan.area_saturated = rsp_sat_ff;

   a_root_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> rem_ff <= {root_ff, 1'b0})
      else $error("root remainder out of bound");

   a_beat_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result beat not loaded from output state");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC && mag_ff.last |=> sum_ff == '0)
      else $error("accumulator not cleared after last triangle");

   a_sat_clips: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && out_free && sat |=> rsp_valid_ff && (&rsp_scaled_ff))
      else $error("saturated area not clipped");

endmodule

[rtl/core/triangle_mesh_area_accumulator_core.sv]
// triangle mesh area accumulator top level with apb register file
// a result beat is given only on a last triangle
// the back sequencer takes one triangle at a time: squaring, the 34-step square root
// and accumulate; a last triangle also goes through the scaling states
// a 2-entry queue lets the 3-stage front take triangles while the back works
// reset is synchronous: pipeline, queue, accumulator and result cleared, registers to defaults
module triangle_mesh_area_accumulator_core (
   input  logic                          clock,
   input  logic                          reset,
   tmaa_req_if.sink                      req_chan,
   tmaa_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tmaa_pkg::ADDR_W-1:0]   paddr,
   input  logic [tmaa_pkg::DATA_W-1:0]   pwdata,
   output logic [tmaa_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   logic [tmaa_pkg::CFG_W-1:0]     card_scale_ff, card_scale_in;
   logic [tmaa_pkg::CFG_W-1:0]     instance_count_ff, instance_count_in;
   logic [tmaa_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           wr_en;

   logic              push_valid, push_ready;
   tmaa_pkg::mag_type push_data;
   logic              pop_valid, pop_ready;
   tmaa_pkg::mag_type pop_data;

   assign pready  = 1'b1;
   assign reg_idx = paddr[tmaa_pkg::ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      card_scale_in     = card_scale_ff;
      instance_count_in = instance_count_ff;
      if (wr_en) begin
         case (reg_idx)
            tmaa_pkg::REG_CARD_SCALE:     card_scale_in     = pwdata[tmaa_pkg::CFG_W-1:0];
            tmaa_pkg::REG_INSTANCE_COUNT: instance_count_in = pwdata[tmaa_pkg::CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tmaa_pkg::REG_CARD_SCALE:     prdata = tmaa_pkg::DATA_W'(card_scale_ff);
         tmaa_pkg::REG_INSTANCE_COUNT: prdata = tmaa_pkg::DATA_W'(instance_count_ff);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_scale_ff     <= tmaa_pkg::CARD_SCALE_RST;
         instance_count_ff <= tmaa_pkg::INSTANCE_COUNT_RST;
      end else begin
         card_scale_ff     <= card_scale_in;
         instance_count_ff <= instance_count_in;
      end
   end

   tmaa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tmaa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tmaa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .card_scale     (card_scale_ff),
      .instance_count (instance_count_ff),
      .rsp_chan       (rsp_chan)
   );

endmodule
